>>> rtl/core/multi_queue_fifo_assert.svh
// ----------------------------------------------------------------------------
// multi_queue_fifo_assert.svh
// Assertion macros for the multi-queue FIFO
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_FIFO_ASSERT_SVH
`define MULTI_QUEUE_FIFO_ASSERT_SVH

// same-cycle implication
`define MQF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("multi_queue_fifo: same-cycle check failed");

// next-cycle implication
`define MQF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("multi_queue_fifo: next-cycle check failed");

`endif

>>> rtl/core/mqf_pkg.sv
// ----------------------------------------------------------------------------
// mqf_pkg
// Shared widths, codes and defaults of the multi-queue FIFO
// ----------------------------------------------------------------------------
package mqf_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 2;
    localparam int QIDX_W   = 3;
    localparam int CFG_W    = 4;

    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [CFG_W-1:0] QUEUES_IN_USE_RST = 4'd8;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_mode MODE_ENQ    = 2'd0;
    localparam t_mode MODE_DEQ    = 2'd1;
    localparam t_mode MODE_QUERY  = 2'd2;
    localparam t_mode MODE_UNUSED = 2'd3;

    localparam t_status ST_ENQ       = 3'd0;
    localparam t_status ST_DEQ       = 3'd1;
    localparam t_status ST_DEQ_EMPTY = 3'd2;
    localparam t_status ST_IS_EMPTY  = 3'd3;
    localparam t_status ST_NOT_EMPTY = 3'd4;
    localparam t_status ST_FULL      = 3'd5;
    localparam t_status ST_INVALID   = 3'd6;

endpackage

>>> rtl/core/mqf_channels.sv
// ----------------------------------------------------------------------------
// mqf_channels
// Request and response channels of the multi-queue FIFO
// ----------------------------------------------------------------------------
interface mqf_req_if;
    logic                              valid;
    logic                              ready;
    mqf_pkg::t_mode                    mode;
    logic [mqf_pkg::QIDX_W-1:0]        queue_index;
    logic signed [mqf_pkg::DATA_W-1:0] value;

    modport source (output valid, mode, queue_index, value, input ready);
    modport sink   (input valid, mode, queue_index, value, output ready);
endinterface

interface mqf_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [mqf_pkg::DATA_W-1:0] data;
    mqf_pkg::t_status                  status;

    modport source (output valid, data, status, input ready);
    modport sink   (input valid, data, status, output ready);
endinterface

>>> rtl/core/mqf_ptr_table.sv
// ----------------------------------------------------------------------------
// mqf_ptr_table
// Per-queue head/count memory; entries never written read as zero
// ----------------------------------------------------------------------------
module mqf_ptr_table #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3,
    parameter int DATA_W = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

>>> rtl/core/mqf_entry_ram.sv
// ----------------------------------------------------------------------------
// mqf_entry_ram
// Shared entry store, one write and one registered read port
// ----------------------------------------------------------------------------
module mqf_entry_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/multi_queue_fifo.sv
// ----------------------------------------------------------------------------
// multi_queue_fifo
// Bank of independent FIFO queues sharing one entry store
// ----------------------------------------------------------------------------
// Each transaction names a queue and a mode (enqueue, dequeue, empty query)
// and returns exactly one response. The head/count memory is read when the
// transaction is accepted in S_IDLE; in S_PTR the block updates it and
// writes or reads the entry store, and in S_OUT it loads the response
// register. Both memories have registered reads. A new transaction is
// accepted while the previous response still waits in the output register;
// a response stalled by the sink holds the block in S_OUT. Queue state
// resets to empty with no clearing pass.
// ----------------------------------------------------------------------------
module multi_queue_fifo #(
    parameter int NUM_QUEUES  = mqf_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mqf_pkg::QUEUE_DEPTH_DEF,
    parameter int VALUE_WIDTH = mqf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [mqf_pkg::CFG_W-1:0]  i_cfg_wr_data,
    mqf_req_if.sink                    i_req,
    mqf_rsp_if.source                  o_rsp
);

    import mqf_pkg::*;

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int DW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = DW + CW;
    localparam int NE = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW = $clog2(NE);
    localparam int LW = ($clog2(NUM_QUEUES + 1) > CFG_W) ? $clog2(NUM_QUEUES + 1) : CFG_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PTR  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [CFG_W-1:0]        r_cfg;
    t_mode                   r_mode;
    logic [QIDX_W-1:0]       r_q;
    logic signed [DATA_W-1:0] r_value;
    t_status                 r_status;
    logic signed [DATA_W-1:0] r_data;
    logic                    r_deq;
    logic                    r_out_valid;
    logic signed [DATA_W-1:0] r_out_data;
    t_status                 r_out_status;

    logic                    w_in_acc;
    logic [LW-1:0]           w_in_q;
    logic [PW-1:0]           w_ptr;
    logic [DW-1:0]           w_head;
    logic [CW-1:0]           w_count;
    logic [LW-1:0]           w_limit;
    logic [LW-1:0]           w_q_ext;
    logic [QW-1:0]           w_qi;
    logic                    w_invalid;
    logic                    w_empty;
    logic                    w_full;
    logic [DW:0]             w_sum;
    logic [DW-1:0]           w_slot;
    logic [DW:0]             w_head_inc;
    logic [DW-1:0]           w_head_nxt;
    logic [AW-1:0]           w_base;
    logic signed [VALUE_WIDTH-1:0] w_store_val;
    logic signed [VALUE_WIDTH-1:0] w_ent_rd;
    t_status                 w_status;
    logic                    w_ptr_we;
    logic [PW-1:0]           w_ptr_wd;
    logic                    w_ent_we;
    logic                    w_ent_re;
    logic [AW-1:0]           w_ent_addr;
    logic                    w_out_load;

    assign w_in_acc    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_q      = LW'(i_req.queue_index);

    mqf_ptr_table #(
        .DEPTH  (NUM_QUEUES),
        .ADDR_W (QW),
        .DATA_W (PW)
    ) u_ptr_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_in_q[QW-1:0]),
        .o_rd_data (w_ptr),
        .i_wr_en   (w_ptr_we),
        .i_wr_addr (w_qi),
        .i_wr_data (w_ptr_wd)
    );

    mqf_entry_ram #(
        .DEPTH  (NE),
        .ADDR_W (AW),
        .DATA_W (VALUE_WIDTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ent_we),
        .i_wr_addr (w_ent_addr),
        .i_wr_data (w_store_val),
        .i_rd_en   (w_ent_re),
        .i_rd_addr (w_ent_addr),
        .o_rd_data (w_ent_rd)
    );

    assign w_head  = w_ptr[PW-1:CW];
    assign w_count = w_ptr[CW-1:0];
    assign w_q_ext = LW'(r_q);
    assign w_qi    = w_q_ext[QW-1:0];
    assign w_limit = (LW'(r_cfg) < LW'(NUM_QUEUES)) ? LW'(r_cfg) : LW'(NUM_QUEUES);

    assign w_invalid = (r_mode == MODE_UNUSED) || (w_q_ext >= w_limit);
    assign w_empty   = (w_count == '0);
    assign w_full    = (w_count == CW'(QUEUE_DEPTH));

    assign w_sum      = (DW+1)'(w_head) + (DW+1)'(w_count);
    assign w_slot     = (w_sum >= (DW+1)'(QUEUE_DEPTH)) ?
                        DW'(w_sum - (DW+1)'(QUEUE_DEPTH)) : DW'(w_sum);
    assign w_head_inc = (DW+1)'(w_head) + (DW+1)'(1);
    assign w_head_nxt = (w_head_inc == (DW+1)'(QUEUE_DEPTH)) ? '0 : DW'(w_head_inc);
    assign w_base     = AW'(AW'(w_qi) * AW'(QUEUE_DEPTH));

    assign w_store_val = VALUE_WIDTH'(r_value);

    always_comb begin
        w_status   = ST_INVALID;
        w_ptr_we   = 1'b0;
        w_ptr_wd   = w_ptr;
        w_ent_we   = 1'b0;
        w_ent_re   = 1'b0;
        w_ent_addr = w_base + AW'(w_head);
        if (r_state == S_PTR && !w_invalid) begin
            case (r_mode)
                MODE_ENQ: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_status   = ST_ENQ;
                        w_ent_we   = 1'b1;
                        w_ent_addr = w_base + AW'(w_slot);
                        w_ptr_we   = 1'b1;
                        w_ptr_wd   = {w_head, w_count + CW'(1)};
                    end
                end
                MODE_DEQ: begin
                    if (w_empty) begin
                        w_status = ST_DEQ_EMPTY;
                    end else begin
                        w_status = ST_DEQ;
                        w_ent_re = 1'b1;
                        w_ptr_we = 1'b1;
                        w_ptr_wd = {w_head_nxt, w_count - CW'(1)};
                    end
                end
                default: begin
                    w_status = w_empty ? ST_IS_EMPTY : ST_NOT_EMPTY;
                end
            endcase
        end
    end

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_PTR;
                end
            end
            S_PTR: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= QUEUES_IN_USE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode  <= i_req.mode;
            r_q     <= i_req.queue_index;
            r_value <= i_req.value;
        end
        if (r_state == S_PTR) begin
            r_status <= w_status;
            r_deq    <= (w_status == ST_DEQ);
            r_data   <= (w_status == ST_ENQ) ? DATA_W'(w_store_val) : '0;
        end
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_data   <= r_deq ? DATA_W'(w_ent_rd) : r_data;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.data   = r_out_data;
    assign o_rsp.status = r_out_status;

`include "multi_queue_fifo_assert.svh"

    `MQF_ASSERT_SAME(a_count_bound, (r_state == S_PTR) && !w_invalid, w_count <= CW'(QUEUE_DEPTH))
    `MQF_ASSERT_NEXT(a_accept_to_ptr, w_in_acc, r_state == S_PTR)
    `MQF_ASSERT_SAME(a_deq_status, (r_state == S_OUT) && r_deq, r_status == ST_DEQ)

endmodule
